@@ hw/rtl/cwap_pkg.sv @@
// Shared types and constants of the windowed current average and peak detector.
`default_nettype none

package cwap_pkg;

    localparam int WIN_W      = 10;
    localparam int SAMPLE_W   = 12;
    localparam int OFFSET_W   = 12;
    localparam int GAIN_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int FRAC_W     = 8;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int CUR_W      = DIFF_W + GAIN_W + 1;
    localparam int SUM_W      = 41;
    localparam int PEAK_W     = 29;
    localparam int DVD_W      = SUM_W - FRAC_W;
    localparam int STEP_W     = $clog2(DVD_W);
    localparam int AVG_W      = 21;
    localparam int PEAK_MA_W  = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_MV    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Q8      = 2'd2;

    localparam logic [WIN_W-1:0]    RST_WINDOW_TICKS = 10'd100;
    localparam logic [OFFSET_W-1:0] RST_OFFSET_MV    = 12'd1650;
    localparam logic [GAIN_W-1:0]   RST_GAIN_Q8      = 16'd19405;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_mv;
        logic                sample_ok;
    } t_in_item;

    typedef struct packed {
        logic signed [AVG_W-1:0] avg_ma;
        logic [PEAK_MA_W-1:0]    peak_ma;
        logic [WIN_W-1:0]        good_count;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic mul;
        logic acc;
        logic div_start;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic win_end;
        logic good_nz;
        logic div_last;
        logic out_busy;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ hw/rtl/current_window_average_peak.sv @@
// Top level of the windowed current average and peak detector.
// Each sample transfer passes the capture, multiply and accumulate steps; the sample
// that closes a window with at least one good sample then passes divider start, the
// bit-serial restoring divide (one quotient bit per cycle over the 33-bit magnitude
// of the sum) and result load. The finished result sits in an output register,
// so intake goes on while it waits; only a window end that finds that register
// still stalled holds off further samples. Configuration writes take effect at once
// and are meant for idle periods.
`default_nettype none

module current_window_average_peak (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire [cwap_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [cwap_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  cwap_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output cwap_pkg::t_out_item             o_out_data
);

    cwap_pkg::t_dp_cmd  cmd;
    cwap_pkg::t_dp_stat stat;

    cwap_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cwap_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

`default_nettype wire

@@ hw/rtl/cwap_ctrl.sv @@
// Sequencer of the detector: sample intake, accumulate, divide and result load.
`default_nettype none

module cwap_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  cwap_pkg::t_dp_stat  i_stat,
    output cwap_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_START,
        S_DIV,
        S_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_in_stall = (r_state != S_IDLE) || !i_rst_n;
        o_cmd = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid && i_rst_n;
                if (o_cmd.capture) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = (i_stat.win_end && i_stat.good_nz) ? S_START : S_IDLE;
            end
            S_START: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load_out = !i_stat.out_busy;
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_load_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> ($past(r_state) == S_DIV || $past(r_state) == S_LOAD))
        else $error("result load not preceded by division");

    a_capture_then_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (o_cmd.mul && o_in_stall))
        else $error("transfer not followed by multiply");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.capture, o_cmd.mul, o_cmd.acc, o_cmd.div_start,
                  o_cmd.div_step, o_cmd.load_out}))
        else $error("overlapping datapath commands");

endmodule

`default_nettype wire

@@ hw/rtl/cwap_dp.sv @@
// Datapath: configuration, current multiply, window accumulators, serial divider, result.
`default_nettype none

module cwap_dp (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire [cwap_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire [cwap_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  cwap_pkg::t_in_item                  i_in_data,
    input  wire                                 i_out_stall,
    output logic                                o_out_valid,
    output cwap_pkg::t_out_item                 o_out_data,
    input  cwap_pkg::t_dp_cmd                   i_cmd,
    output cwap_pkg::t_dp_stat                  o_stat
);

    logic [cwap_pkg::WIN_W-1:0]    r_window;
    logic [cwap_pkg::OFFSET_W-1:0] r_offset;
    logic [cwap_pkg::GAIN_W-1:0]   r_gain;

    cwap_pkg::t_in_item r_in;

    logic signed [cwap_pkg::DIFF_W-1:0] diff;
    logic signed [cwap_pkg::CUR_W-1:0]  r_cur;
    logic                               r_cur_ok;

    logic [cwap_pkg::WIN_W-1:0]         r_tick;
    logic [cwap_pkg::WIN_W-1:0]         r_good;
    logic signed [cwap_pkg::SUM_W-1:0]  r_sum;
    logic [cwap_pkg::PEAK_W-1:0]        r_peak;

    logic [cwap_pkg::WIN_W-1:0] n_tick;
    logic [cwap_pkg::WIN_W-1:0] n_good;
    logic [cwap_pkg::WIN_W-1:0] win_eff;

    logic [cwap_pkg::SUM_W-1:0]  sum_mag;
    logic [cwap_pkg::DVD_W-1:0]  r_quo;
    logic [cwap_pkg::WIN_W-1:0]  r_rem;
    logic [cwap_pkg::STEP_W-1:0] r_step;
    logic                        r_neg;
    logic [cwap_pkg::WIN_W:0]    rem_sh;
    logic                        q_bit;
    logic [cwap_pkg::AVG_W-1:0]  quo_t;

    logic                r_out_valid;
    cwap_pkg::t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= cwap_pkg::RST_WINDOW_TICKS;
            r_offset <= cwap_pkg::RST_OFFSET_MV;
            r_gain   <= cwap_pkg::RST_GAIN_Q8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cwap_pkg::CFG_WINDOW_TICKS: r_window <= i_cfg_data[cwap_pkg::WIN_W-1:0];
                cwap_pkg::CFG_OFFSET_MV:    r_offset <= i_cfg_data[cwap_pkg::OFFSET_W-1:0];
                cwap_pkg::CFG_GAIN_Q8:      r_gain   <= i_cfg_data[cwap_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign diff = $signed({1'b0, r_in.sample_mv}) - $signed({1'b0, r_offset});

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_data;
        end
        if (i_cmd.mul) begin
            r_cur    <= cwap_pkg::CUR_W'(diff) *
                        cwap_pkg::CUR_W'($signed({1'b0, r_gain}));
            r_cur_ok <= r_in.sample_ok;
        end
    end

    assign n_tick  = r_tick + 1'b1;
    assign n_good  = r_cur_ok ? r_good + 1'b1 : r_good;
    assign win_eff = (r_window == '0) ? cwap_pkg::WIN_W'(1) : r_window;

    assign o_stat.win_end = (n_tick == '0) || (n_tick >= win_eff);
    assign o_stat.good_nz = (n_good != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            r_good <= '0;
            r_sum  <= '0;
            r_peak <= '0;
        end else if (i_cmd.acc && o_stat.win_end && !o_stat.good_nz) begin
            r_tick <= '0;
            r_good <= '0;
            r_sum  <= '0;
            r_peak <= '0;
        end else if (i_cmd.acc) begin
            r_tick <= n_tick;
            r_good <= n_good;
            if (r_cur_ok) begin
                r_sum <= r_sum + cwap_pkg::SUM_W'(r_cur);
                if (r_cur > $signed({1'b0, r_peak})) begin
                    r_peak <= r_cur[cwap_pkg::PEAK_W-1:0];
                end
            end
        end else if (i_cmd.load_out) begin
            r_tick <= '0;
            r_good <= '0;
            r_sum  <= '0;
            r_peak <= '0;
        end
    end

    assign sum_mag = r_sum[cwap_pkg::SUM_W-1] ? (~r_sum + 1'b1) : r_sum;
    assign rem_sh  = {r_rem, r_quo[cwap_pkg::DVD_W-1]};
    assign q_bit   = (rem_sh >= {1'b0, r_good});
    assign o_stat.div_last = (r_step == cwap_pkg::STEP_W'(cwap_pkg::DVD_W - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_quo  <= sum_mag[cwap_pkg::SUM_W-1:cwap_pkg::FRAC_W];
            r_rem  <= '0;
            r_step <= '0;
            r_neg  <= r_sum[cwap_pkg::SUM_W-1];
        end else if (i_cmd.div_step) begin
            r_rem  <= q_bit ? cwap_pkg::WIN_W'(rem_sh - {1'b0, r_good})
                            : rem_sh[cwap_pkg::WIN_W-1:0];
            r_quo  <= {r_quo[cwap_pkg::DVD_W-2:0], q_bit};
            r_step <= r_step + 1'b1;
        end
    end

    assign quo_t = r_quo[cwap_pkg::AVG_W-1:0];
    assign o_stat.out_busy = r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.avg_ma     <= r_neg ? $signed(-quo_t) : $signed(quo_t);
            r_out.peak_ma    <= r_peak[cwap_pkg::FRAC_W +: cwap_pkg::PEAK_MA_W];
            r_out.good_count <= r_good;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_rise_needs_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.load_out))
        else $error("result raised without a load");

    a_good_le_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_good <= r_tick)
        else $error("good count exceeds tick count");

    a_clear_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> (r_tick == '0 && r_good == '0 && r_sum == '0))
        else $error("window state not cleared after result load");

endmodule

`default_nettype wire

@@ bench/cwap_report_checker.sv @@
// Checker for the window detector: watches both channels, predicts each report and compares.
`timescale 1ns / 1ps

module cwap_report_checker (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire [cwap_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [cwap_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                             i_in_valid,
    input  wire                             i_in_stall,
    input  cwap_pkg::t_in_item              i_in_data,
    input  wire                             i_out_valid,
    input  wire                             i_out_stall,
    input  cwap_pkg::t_out_item             i_out_data,
    output int                              o_errors,
    output int                              o_waiting,
    output int                              o_reports
);

    logic [cwap_pkg::WIN_W-1:0]    window_ticks;
    logic [cwap_pkg::OFFSET_W-1:0] offset_mv;
    logic [cwap_pkg::GAIN_W-1:0]   gain_q8;
    logic [cwap_pkg::WIN_W-1:0]    tick_index;
    logic [cwap_pkg::WIN_W-1:0]    good_samples;
    longint                        sum_q8;
    longint                        peak_q8;
    int                            errors = 0;
    int                            reports = 0;
    cwap_pkg::t_out_item           expected_reports[$];

    function automatic void clear_window();
        tick_index   = '0;
        good_samples = '0;
        sum_q8       = 0;
        peak_q8      = 0;
    endfunction

    function automatic void accumulate_sample(cwap_pkg::t_in_item s);
        longint                     mv;
        longint                     off;
        longint                     gain;
        longint                     cur;
        longint                     div;
        longint                     avg;
        longint                     peak_ma;
        logic [cwap_pkg::WIN_W-1:0] span;
        cwap_pkg::t_out_item        rep;
        mv   = s.sample_mv;
        off  = offset_mv;
        gain = gain_q8;
        span = (window_ticks == '0) ? cwap_pkg::WIN_W'(1) : window_ticks;
        if (s.sample_ok) begin
            cur = (mv - off) * gain;
            sum_q8 += cur;
            if (cur > peak_q8)
                peak_q8 = cur;
            good_samples += 1'b1;
        end
        tick_index += 1'b1;
        if (tick_index != '0 && tick_index < span)
            return;
        if (good_samples != '0) begin
            div            = good_samples;
            div            = div * 256;
            avg            = sum_q8 / div;
            peak_ma        = peak_q8 >>> cwap_pkg::FRAC_W;
            rep.avg_ma     = avg[cwap_pkg::AVG_W-1:0];
            rep.peak_ma    = peak_ma[cwap_pkg::PEAK_MA_W-1:0];
            rep.good_count = good_samples;
            expected_reports.push_back(rep);
        end
        clear_window();
    endfunction

    always @(posedge i_clk) begin
        cwap_pkg::t_out_item want;
        if (!i_rst_n) begin
            window_ticks = cwap_pkg::RST_WINDOW_TICKS;
            offset_mv    = cwap_pkg::RST_OFFSET_MV;
            gain_q8      = cwap_pkg::RST_GAIN_Q8;
            clear_window();
            expected_reports.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                reports++;
                if (expected_reports.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected report: avg %0d peak %0d count %0d",
                                 i_out_data.avg_ma, i_out_data.peak_ma,
                                 i_out_data.good_count);
                end else begin
                    want = expected_reports.pop_front();
                    if (i_out_data !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display({"report %0d mismatch: expected avg %0d peak %0d ",
                                      "count %0d, got avg %0d peak %0d count %0d"},
                                     reports, want.avg_ma, want.peak_ma, want.good_count,
                                     i_out_data.avg_ma, i_out_data.peak_ma,
                                     i_out_data.good_count);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                accumulate_sample(i_in_data);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cwap_pkg::CFG_WINDOW_TICKS:
                        window_ticks = i_cfg_data[cwap_pkg::WIN_W-1:0];
                    cwap_pkg::CFG_OFFSET_MV:
                        offset_mv    = i_cfg_data[cwap_pkg::OFFSET_W-1:0];
                    cwap_pkg::CFG_GAIN_Q8:
                        gain_q8      = i_cfg_data[cwap_pkg::GAIN_W-1:0];
                    default: ;
                endcase
            end
        end
        o_errors  <= errors;
        o_waiting <= expected_reports.size();
        o_reports <= reports;
    end

endmodule

@@ bench/testbench.sv @@
// Top of the window detector bench: clock, reset, register settings, sample stimulus, verdict.
`timescale 1ns / 1ps

module testbench;

    localparam logic [cwap_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int RANDOM_SAMPLES = 230;
    localparam int LONG_WINDOW    = 300;
    localparam int DRAIN_CYCLES   = 64;
    localparam int IDLE_PCT       = 8;
    localparam int MAX_MV         = 4095;
    localparam int MAX_GAIN       = 65535;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_we    = 1'b0;
    logic [cwap_pkg::CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [cwap_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                            i_in_valid  = 1'b0;
    cwap_pkg::t_in_item              i_in_data   = '0;
    logic                            i_out_stall = 1'b0;
    logic                            o_in_stall;
    logic                            o_out_valid;
    cwap_pkg::t_out_item             o_out_data;
    logic                            calm        = 1'b0;

    int mismatches;
    int pending;
    int reports;
    int sent     = 0;
    int settings = 0;

    current_window_average_peak uut (
        .i_clk,
        .i_rst_n,
        .i_cfg_we,
        .i_cfg_idx,
        .i_cfg_data,
        .i_in_valid,
        .o_in_stall,
        .i_in_data,
        .o_out_valid,
        .i_out_stall,
        .o_out_data
    );

    cwap_report_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .o_errors    (mismatches),
        .o_waiting   (pending),
        .o_reports   (reports)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    task automatic send_sample(input int mv, input logic ok);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_in_data.sample_mv <= mv[cwap_pkg::SAMPLE_W-1:0];
        i_in_data.sample_ok <= ok;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [cwap_pkg::CFG_DATA_W-1:0] win,
                                input logic [cwap_pkg::CFG_DATA_W-1:0] off,
                                input logic [cwap_pkg::CFG_DATA_W-1:0] gain);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= cwap_pkg::CFG_WINDOW_TICKS;
        i_cfg_data <= win;
        @(posedge i_clk);
        i_cfg_idx  <= cwap_pkg::CFG_OFFSET_MV;
        i_cfg_data <= off;
        @(posedge i_clk);
        i_cfg_idx  <= cwap_pkg::CFG_GAIN_Q8;
        i_cfg_data <= gain;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SPARE;
        i_cfg_data <= cwap_pkg::CFG_DATA_W'($urandom);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        settings++;
    endtask

    function automatic int pick_sample(input int off);
        int r;
        int v;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 0;
        if (r == 1)
            return MAX_MV;
        if (r < 6) begin
            v = off + $urandom_range(0, 64) - 32;
            return (v < 0) ? 0 : (v > MAX_MV) ? MAX_MV : v;
        end
        return $urandom_range(0, MAX_MV);
    endfunction

    initial begin
        int win;
        int span;
        int off;
        int gain;
        int count;
        int random_sent;
        logic silent;
        int r;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, then shorten the window under a partial one
        send_sample(1650, 1'b1);
        send_sample(MAX_MV, 1'b1);
        send_sample(0, 1'b1);
        settle();
        program_regs(16'd2, 16'd1650, 16'd19405);
        send_sample(2000, 1'b0);
        settle();

        // zero window acts as one; largest positive current
        program_regs(16'h0000, 16'd0, 16'(MAX_GAIN));
        send_sample(MAX_MV, 1'b1);
        send_sample(0, 1'b1);
        send_sample(MAX_MV, 1'b0);
        settle();

        // upper data bits dropped; most negative current
        program_regs(16'hFC01, 16'hF000 | 16'(MAX_MV), 16'(MAX_GAIN));
        send_sample(0, 1'b1);
        send_sample(MAX_MV, 1'b1);
        settle();

        program_regs(16'd3, 16'd2048, 16'd0);
        send_sample(MAX_MV, 1'b1);
        send_sample(0, 1'b1);
        send_sample(1, 1'b0);
        settle();

        // small negative mean truncates toward zero
        program_regs(16'd4, 16'd1000, 16'd100);
        send_sample(999, 1'b1);
        send_sample(998, 1'b1);
        send_sample(1003, 1'b0);
        send_sample(1000, 1'b1);
        settle();

        // long window with no idling on either side
        calm <= 1'b1;
        program_regs(16'(LONG_WINDOW), 16'd0, 16'(MAX_GAIN));
        repeat (LONG_WINDOW)
            send_sample(($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_MV) : MAX_MV,
                        1'b1);
        settle();
        calm <= 1'b0;

        random_sent = 0;
        while (random_sent < RANDOM_SAMPLES) begin
            r = $urandom_range(0, 19);
            win = (r == 0) ? 0 : (r == 1) ? $urandom_range(17, 80) : $urandom_range(1, 16);
            span = (win == 0) ? 1 : win;
            r = $urandom_range(0, 9);
            off = (r == 0) ? 0 : (r == 1) ? MAX_MV :
                  (r < 6) ? 1650 + $urandom_range(0, 200) - 100 : $urandom_range(0, MAX_MV);
            r = $urandom_range(0, 9);
            gain = (r == 0) ? 0 : (r == 1) ? MAX_GAIN :
                   (r < 5) ? 19405 : $urandom_range(0, MAX_GAIN);
            silent = ($urandom_range(0, 9) == 0);
            count = $urandom_range(1, 3 * span + 1);
            if (count > 60)
                count = 60;
            if (count > RANDOM_SAMPLES - random_sent)
                count = RANDOM_SAMPLES - random_sent;
            settle();
            program_regs({6'($urandom), 10'(win)}, {4'($urandom), 12'(off)}, 16'(gain));
            repeat (count) begin
                send_sample(pick_sample(off), !silent && ($urandom_range(0, 99) < 85));
                random_sent++;
            end
        end
        settle();

        $display("Checked %0d window reports from %0d samples over %0d register settings.",
                 reports, sent, settings);
        $display("Windows spanned 1 to %0d ticks; offsets and gains hit both range ends.",
                 LONG_WINDOW);
        if (mismatches == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #1000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
